>>> hdl/serial_counter_radix_formatter_unit_macros.svh
// Assertion helpers for the serial counter formatter checks.
`ifndef SERIAL_COUNTER_RADIX_FORMATTER_UNIT_MACROS_SVH
`define SERIAL_COUNTER_RADIX_FORMATTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SCRFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SCRFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/scrfu_pkg.sv
package scrfu_pkg;

  localparam int SCRFU_MAX_SYMBOLS = 64;
  localparam int SCRFU_MAX_DIGITS  = 16;
  localparam int SCRFU_VALUE_BITS  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Command codes
  localparam logic [2:0] CMD_WRITE_SYM  = 3'd0;
  localparam logic [2:0] CMD_LOAD       = 3'd1;
  localparam logic [2:0] CMD_ADVANCE    = 3'd2;
  localparam logic [2:0] CMD_FORMAT_CNT = 3'd3;
  localparam logic [2:0] CMD_FORMAT_VAL = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd4;

  // Result kinds
  localparam logic KIND_SYMBOL  = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  symbol_index;
    logic [7:0]  symbol_code;
    logic [31:0] value;
    logic [15:0] step;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] symbol_out;
    logic       advance_ok;
    logic       digits_overflow;
    logic       last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/scrfu_divider.sv
module scrfu_divider import scrfu_pkg::*; #(
  parameter int VALUE_BITS = SCRFU_VALUE_BITS,
  parameter int BASE_W     = 7,
  parameter int REM_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [BASE_W-1:0]     divisor_i,
  output div_stat_t             stat_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [REM_W-1:0]      remainder_o
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  run_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS-1:0] quo_q;
  logic [BASE_W-1:0]     rem_q, div_q;

  logic [BASE_W:0]   trial;
  logic [BASE_W:0]   diff;
  logic              ge;
  logic [BASE_W-1:0] rem_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[VALUE_BITS-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    rem_d = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(VALUE_BITS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[VALUE_BITS-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy  = run_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = REM_W'(rem_q);

endmodule

>>> hdl/serial_counter_radix_formatter_unit.sv
// Serial-number counter with a programmable symbol alphabet.
// Command channel: start with cmd_i; a command is taken on a clock edge
// with start high and busy low. Write-symbol, load and unused commands
// finish at once and give no result. Advance gives one status word in the
// cycle after it is taken and does not raise busy.
// Format commands raise busy and give digit_count symbol words (one if
// digit_count is 0, at most MAX_DIGITS), most significant first, last set
// on the final one. All digits are first worked out in the shared
// bit-serial divider, then each symbol passes a table read (ST_RD) and an
// output register (ST_OUT). busy drops in the cycle the final symbol is
// shown.
// Result channel: result_valid_o marks each word for exactly one cycle;
// the receiver cannot stall it.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write a register on a
// clock edge; write only while busy is low and no result is pending.
// Reset: radix 10, digit_count 8, min 0, max all ones, wrap off, counter 0.
// The symbol table holds garbage until written.
module serial_counter_radix_formatter_unit import scrfu_pkg::*; #(
  parameter int MAX_SYMBOLS = SCRFU_MAX_SYMBOLS,
  parameter int MAX_DIGITS  = SCRFU_MAX_DIGITS,
  parameter int VALUE_BITS  = SCRFU_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  output logic                  result_valid_o,
  output result_t               result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SIW = $clog2(MAX_SYMBOLS);
  localparam int BW  = $clog2(MAX_SYMBOLS + 1);
  localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW  = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q;

  logic [6:0]  radix_q;
  logic [4:0]  digit_count_q;
  logic [31:0] min_q, max_q;
  logic        wrap_q;

  logic [VALUE_BITS-1:0] counter_q;
  logic [DIW-1:0]        k_q, pos_q, nlast_q;
  logic                  ovf_q;

  logic [7:0]     sym_mem [MAX_SYMBOLS];
  logic [7:0]     sym_rd_q;
  logic [SIW-1:0] dig_buf [MAX_DIGITS];

  logic    res_valid_q;
  result_t res_q;

  logic                  accept, is_format, sym_we;
  logic [BW-1:0]         base;
  logic [DIW-1:0]        nlast;
  logic [CW-1:0]         sum;
  logic                  exceeds, cnt_gt_max;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] quotient;
  logic [SIW-1:0]        remainder;
  logic                  digit_done, final_digit;

  assign busy      = state_q != ST_IDLE;
  assign accept    = start && !busy;
  assign is_format = (cmd_i.command == CMD_FORMAT_CNT) || (cmd_i.command == CMD_FORMAT_VAL);
  assign sym_we    = accept && (cmd_i.command == CMD_WRITE_SYM)
                     && (32'(cmd_i.symbol_index) < 32'(MAX_SYMBOLS));

  always_comb begin
    if (radix_q < 7'd2) begin
      base = BW'(2);
    end else if (32'(radix_q) > 32'(MAX_SYMBOLS)) begin
      base = BW'(MAX_SYMBOLS);
    end else begin
      base = BW'(radix_q);
    end
    if (digit_count_q == 5'd0) begin
      nlast = '0;
    end else if (32'(digit_count_q) > 32'(MAX_DIGITS)) begin
      nlast = DIW'(MAX_DIGITS - 1);
    end else begin
      nlast = DIW'(digit_count_q - 5'd1);
    end
  end

  assign sum        = CW'(counter_q) + CW'(cmd_i.step);
  assign exceeds    = sum > CW'(max_q);
  assign cnt_gt_max = CW'(counter_q) > CW'(max_q);

  assign digit_done  = (state_q == ST_DIV) && div_stat.done;
  assign final_digit = k_q == nlast_q;
  assign div_start   = (accept && is_format) || (digit_done && !final_digit);

  always_comb begin
    if (state_q == ST_DIV) begin
      div_dividend = quotient;
    end else if (cmd_i.command == CMD_FORMAT_CNT) begin
      div_dividend = counter_q;
    end else begin
      div_dividend = VALUE_BITS'(cmd_i.value);
    end
  end

  scrfu_divider #(
    .VALUE_BITS (VALUE_BITS),
    .BASE_W     (BW),
    .REM_W      (SIW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (base),
    .stat_o      (div_stat),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= 7'd10;
      digit_count_q <= 5'd8;
      min_q         <= '0;
      max_q         <= '1;
      wrap_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:       radix_q       <= cfg_data_i[6:0];
        REG_DIGIT_COUNT: digit_count_q <= cfg_data_i[4:0];
        REG_MIN_VALUE:   min_q         <= cfg_data_i;
        REG_MAX_VALUE:   max_q         <= cfg_data_i;
        REG_WRAP_ENABLE: wrap_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counter_q   <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      nlast_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_i.command == CMD_LOAD) begin
              counter_q <= VALUE_BITS'(cmd_i.value);
            end else if (cmd_i.command == CMD_ADVANCE) begin
              res_valid_q <= 1'b1;
              if (wrap_q) begin
                counter_q <= exceeds ? VALUE_BITS'(min_q) : VALUE_BITS'(sum);
              end else if (!cnt_gt_max) begin
                counter_q <= VALUE_BITS'(sum);
              end
            end else if (is_format) begin
              k_q     <= '0;
              nlast_q <= nlast;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (digit_done) begin
            if (final_digit) begin
              ovf_q   <= |quotient;
              pos_q   <= nlast_q;
              state_q <= ST_RD;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          res_valid_q <= 1'b1;
          if (pos_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            pos_q   <= pos_q - 1'b1;
            state_q <= ST_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      res_q.result_kind     <= KIND_SYMBOL;
      res_q.symbol_out      <= sym_rd_q;
      res_q.advance_ok      <= 1'b0;
      res_q.digits_overflow <= ovf_q;
      res_q.last            <= pos_q == '0;
    end else if (accept && (cmd_i.command == CMD_ADVANCE)) begin
      res_q.result_kind     <= KIND_ADVANCE;
      res_q.symbol_out      <= 8'd0;
      res_q.advance_ok      <= wrap_q || !cnt_gt_max;
      res_q.digits_overflow <= 1'b0;
      res_q.last            <= 1'b1;
    end
  end

  // Digit buffer, filled least significant first
  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      dig_buf[k_q] <= remainder;
    end
  end

  // Symbol table
  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[SIW'(cmd_i.symbol_index)] <= cmd_i.symbol_code;
    end
    if (state_q == ST_RD) begin
      sym_rd_q <= sym_mem[dig_buf[pos_q]];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> hdl/scrfu_checker.sv
`include "serial_counter_radix_formatter_unit_macros.svh"

module scrfu_checker import scrfu_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd_i,
  input logic    result_valid_o,
  input result_t result_o
);

  `SCRFU_ASSERT_NEXT(a_adv_status, start && !busy && (cmd_i.command == CMD_ADVANCE), result_valid_o && (result_o.result_kind == KIND_ADVANCE), "advance gave no status word")

  `SCRFU_ASSERT_NOW(a_adv_shape, result_valid_o && (result_o.result_kind == KIND_ADVANCE), result_o.last && !result_o.digits_overflow, "advance status word malformed")

  `SCRFU_ASSERT_NOW(a_sym_busy, result_valid_o && (result_o.result_kind == KIND_SYMBOL) && !result_o.last, busy, "busy dropped inside a format")

  `SCRFU_ASSERT_NEXT(a_sym_gap, result_valid_o && (result_o.result_kind == KIND_SYMBOL) && !result_o.last, !result_valid_o, "symbol words back to back")

endmodule

bind serial_counter_radix_formatter_unit scrfu_checker u_scrfu_checker (.*);
